// ----- hdl/crcfr_pkg.sv -----
package crcfr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int IDX_W  = 6;
  localparam int CRC_W  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
  localparam logic [BYTE_W-1:0] SOF_RESET = 8'hAA;
  localparam logic [LEN_W-1:0]  MAX_RESET = 7'd64;

  // register select, taken from paddr[2]
  localparam logic REG_SOF = 1'b0;
  localparam logic REG_MAX = 1'b1;

  typedef struct packed {
    logic sof_hit;
    logic take_id;
    logic take_len;
    logic take_data;
    logic take_crc_lo;
    logic emit_start;
    logic rd_en;
    logic advance;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sof_match;
    logic len_over;
    logic len_zero;
    logic data_done;
    logic crc_match;
    logic emit_last;
    logic out_free;
  } dp_status_t;

  // one byte of crc-16, msb first
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/crc_frame_receiver.sv -----
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------------
// input    | in_valid / in_ready    | data_byte
// output   | out_valid / out_ready  | frame_id, frame_len, byte_index, payload_byte,
//          |                        | last_item
// config   | apb psel/penable/...   | sof_byte @0x0, max_payload @0x4
//
// one received byte is taken per cycle while parsing; the running crc is
// updated in the same cycle by a single byte-wide crc step
// a good frame replays n payload results (one if empty) from the registered
// store read, one per cycle as out_ready allows; input is held off during the replay
// rst is synchronous and clears the parser to hunting; no store clearing pass
// the output register lets the next frame's bytes come in while the last
// result waits to be taken
module crc_frame_receiver #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [crcfr_pkg::BYTE_W-1:0]          data_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [crcfr_pkg::BYTE_W-1:0]          frame_id,
  output logic [crcfr_pkg::LEN_W-1:0]           frame_len,
  output logic [crcfr_pkg::IDX_W-1:0]           byte_index,
  output logic [crcfr_pkg::BYTE_W-1:0]          payload_byte,
  output logic                                  last_item,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [crcfr_pkg::ADDR_W-1:0]          paddr,
  input  logic [crcfr_pkg::DATA_W-1:0]          pwdata,
  output logic [crcfr_pkg::DATA_W-1:0]          prdata,
  output logic                                  pready
);
  import crcfr_pkg::*;

  logic [BYTE_W-1:0] sof_byte;
  logic [LEN_W-1:0]  max_payload;
  logic              reg_sel;
  dp_cmd_t           cmd;
  dp_status_t        st;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sof_byte    <= SOF_RESET;
      max_payload <= MAX_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_SOF: sof_byte    <= pwdata[BYTE_W-1:0];
        REG_MAX: max_payload <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SOF: prdata = {{(DATA_W-BYTE_W){1'b0}}, sof_byte};
      REG_MAX: prdata = {{(DATA_W-LEN_W){1'b0}}, max_payload};
      default: prdata = '0;
    endcase
  end

  crcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  crcfr_datapath #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (data_byte),
    .sof_byte     (sof_byte),
    .max_payload  (max_payload),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_id     (frame_id),
    .frame_len    (frame_len),
    .byte_index   (byte_index),
    .payload_byte (payload_byte),
    .last_item    (last_item)
  );

endmodule

// ----- hdl/crcfr_ctrl.sv -----
module crcfr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  crcfr_pkg::dp_status_t st,
  output crcfr_pkg::dp_cmd_t    cmd
);
  import crcfr_pkg::*;

  typedef enum logic [2:0] {
    S_HUNT,
    S_ID,
    S_LEN,
    S_DATA,
    S_CRC_LO,
    S_CRC_HI,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state != S_EMIT);
  assign accept   = in_valid & in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_HUNT: begin
        if (accept && st.sof_match) begin
          cmd.sof_hit = 1'b1;
          state_next  = S_ID;
        end
      end
      S_ID: begin
        if (accept) begin
          cmd.take_id = 1'b1;
          state_next  = S_LEN;
        end
      end
      S_LEN: begin
        if (accept) begin
          cmd.take_len = 1'b1;
          if (st.len_over) begin
            state_next = S_HUNT;
          end else if (st.len_zero) begin
            state_next = S_CRC_LO;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (accept) begin
          cmd.take_data = 1'b1;
          if (st.data_done) begin
            state_next = S_CRC_LO;
          end
        end
      end
      S_CRC_LO: begin
        if (accept) begin
          cmd.take_crc_lo = 1'b1;
          state_next      = S_CRC_HI;
        end
      end
      S_CRC_HI: begin
        if (accept) begin
          // first store read goes out with the check
          cmd.emit_start = 1'b1;
          cmd.rd_en      = 1'b1;
          state_next     = st.crc_match ? S_EMIT : S_HUNT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.emit_last) begin
            state_next = S_HUNT;
          end else begin
            cmd.advance = 1'b1;
            cmd.rd_en   = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/crcfr_datapath.sv -----
module crcfr_datapath #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [crcfr_pkg::BYTE_W-1:0]          data_byte,
  input  logic [crcfr_pkg::BYTE_W-1:0]          sof_byte,
  input  logic [crcfr_pkg::LEN_W-1:0]           max_payload,
  input  crcfr_pkg::dp_cmd_t                    cmd,
  output crcfr_pkg::dp_status_t                 st,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [crcfr_pkg::BYTE_W-1:0]          frame_id,
  output logic [crcfr_pkg::LEN_W-1:0]           frame_len,
  output logic [crcfr_pkg::IDX_W-1:0]           byte_index,
  output logic [crcfr_pkg::BYTE_W-1:0]          payload_byte,
  output logic                                  last_item
);
  import crcfr_pkg::*;

  localparam int MEM_AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(PAYLOAD_DEPTH);

  logic [BYTE_W-1:0] mem [PAYLOAD_DEPTH];
  logic [BYTE_W-1:0] rd_data;

  logic [BYTE_W-1:0] held_id;
  logic [LEN_W-1:0]  held_len;
  logic [LEN_W-1:0]  byte_count;
  logic [BYTE_W-1:0] crc_lo;
  logic [CRC_W-1:0]  running_crc;
  logic [LEN_W-1:0]  emit_idx;
  logic [LEN_W-1:0]  emit_idx_next;

  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  count_inc;
  logic [LEN_W-1:0]  run_len;

  assign limit     = (max_payload < DEPTH_LEN) ? max_payload : DEPTH_LEN;
  assign count_inc = byte_count + LEN_W'(1);
  assign run_len   = (held_len == '0) ? LEN_W'(1) : held_len;

  always_comb begin
    if (cmd.emit_start) begin
      emit_idx_next = '0;
    end else if (cmd.advance) begin
      emit_idx_next = emit_idx + LEN_W'(1);
    end else begin
      emit_idx_next = emit_idx;
    end
  end

  assign st.sof_match = (data_byte == sof_byte);
  assign st.len_over  = (data_byte > {1'b0, limit});
  assign st.len_zero  = (data_byte == '0);
  assign st.data_done = (count_inc >= held_len);
  assign st.crc_match = ({data_byte, crc_lo} == running_crc);
  assign st.emit_last = ((emit_idx + LEN_W'(1)) == run_len);
  assign st.out_free  = !out_valid || out_ready;

  // frame fields and running crc
  always_ff @(posedge clk) begin
    if (rst) begin
      held_id     <= '0;
      held_len    <= '0;
      byte_count  <= '0;
      crc_lo      <= '0;
      running_crc <= CRC_INIT;
      emit_idx    <= '0;
    end else begin
      if (cmd.sof_hit) begin
        running_crc <= CRC_INIT;
      end else if (cmd.take_id || cmd.take_len || cmd.take_data) begin
        running_crc <= crc_feed(running_crc, data_byte);
      end
      if (cmd.take_id) begin
        held_id <= data_byte;
      end
      if (cmd.take_len) begin
        held_len   <= data_byte[LEN_W-1:0];
        byte_count <= '0;
      end else if (cmd.take_data) begin
        byte_count <= count_inc;
      end
      if (cmd.take_crc_lo) begin
        crc_lo <= data_byte;
      end
      emit_idx <= emit_idx_next;
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (cmd.take_data) begin
      mem[byte_count[MEM_AW-1:0]] <= data_byte;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[emit_idx_next[MEM_AW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      frame_id     <= held_id;
      frame_len    <= held_len;
      byte_index   <= emit_idx[IDX_W-1:0];
      payload_byte <= (held_len == '0) ? '0 : rd_data;
      last_item    <= st.emit_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.take_data |-> (byte_count < DEPTH_LEN))
    else $error("payload write beyond store depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> (!st.emit_last && (emit_idx < run_len)))
    else $error("frame run stepped past its end");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && st.emit_last) |=> !cmd.out_load)
    else $error("result loaded after last of run");
`endif

endmodule
